### rtl/scanline_triangle_span_generator_defines.svh
// assertion macros for the span generator
`ifndef SCANLINE_TRIANGLE_SPAN_GENERATOR_DEFINES_SVH
`define SCANLINE_TRIANGLE_SPAN_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define STSG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STSG_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STSG_ASSERT(lbl, clk, rst, prop, msg)
`define STSG_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### rtl/stsg_pkg.sv
package stsg_pkg;

   localparam int COLOR_BITS = 32;

   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_SORT     = 10'b0000000010,
      ST_MUL      = 10'b0000000100,
      ST_DIV_GO   = 10'b0000001000,
      ST_DIV_WAIT = 10'b0000010000,
      ST_LOAD_TOP = 10'b0000100000,
      ST_EMIT_TOP = 10'b0001000000,
      ST_LOAD_BOT = 10'b0010000000,
      ST_EMIT_BOT = 10'b0100000000,
      ST_DRAIN    = 10'b1000000000
   } state_type;

   // divisions done per triangle, in order
   typedef enum logic [2:0] {
      JOB_SPLIT = 3'd0,
      JOB_TOP_A = 3'd1,
      JOB_TOP_B = 3'd2,
      JOB_BOT_A = 3'd3,
      JOB_BOT_B = 3'd4
   } job_type;

   // control from sequencer to span stepper
   typedef struct packed {
      logic load;
      logic step;
      logic step_up;
      logic last;
   } span_ctl_type;

endpackage

### rtl/stsg_div.sv
module stsg_div #(
   parameter int NW = 22,
   parameter int DW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot,
   output logic          rem_nz
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;

   logic [DW:0]   trial;
   logic [DW+1:0] diff;
   logic          ge;

   // one restoring step per cycle
   assign trial = {rem_ff, quo_ff[NW-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign ge    = !diff[DW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == CW'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CW'(NW);
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NW-2:0], ge};
         rem_ff <= ge ? diff[DW-1:0] : trial[DW-1:0];
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done   = done_ff;
   assign quot   = quo_ff;
   assign rem_nz = |rem_ff;

endmodule

### rtl/stsg_span.sv
module stsg_span import stsg_pkg::*; #(
   parameter int CB = 6,
   parameter int FB = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  span_ctl_type                ctl,
   input  logic [CB-1:0]               x_init,
   input  logic [CB-1:0]               row,
   input  logic signed [CB+FB+1:0]     slope_a,
   input  logic signed [CB+FB+1:0]     slope_b,
   output logic                        strobe,
   output logic [CB-1:0]               span_row,
   output logic [CB-1:0]               span_start,
   output logic signed [CB:0]          span_length,
   output logic                        last_span
);

   localparam int AW = CB + FB + 2;
   localparam logic [AW-1:0] HALF = AW'(1) << (FB - 1);

   logic signed [AW-1:0] acc_a_ff, acc_b_ff;
   logic                 v1_ff, last1_ff;
   logic [CB-1:0]        row1_ff;
   logic                 strobe_ff, last_ff;
   logic [CB-1:0]        row_ff, start_ff;
   logic [CB:0]          len_ff;
   logic [CB:0]          rnd_a, rnd_b, len_in;

   // round half away from zero to an integer
   function automatic logic [CB:0] round_x(input logic signed [AW-1:0] v);
      logic [AW-1:0] neg_v;
      logic [AW-1:0] mag;
      logic [AW-1:0] sum;
      logic [CB:0]   r;
      neg_v = ~v + AW'(1);
      mag   = v[AW-1] ? neg_v : v;
      sum   = mag + HALF;
      r     = sum[FB +: CB+1];
      return v[AW-1] ? (~r + (CB+1)'(1)) : r;
   endfunction

   assign rnd_a  = round_x(acc_a_ff);
   assign rnd_b  = round_x(acc_b_ff);
   assign len_in = rnd_b - rnd_a;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= ctl.step;
         strobe_ff <= v1_ff;
      end
   end

   // edge accumulators step, then round into the output register
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         acc_a_ff <= signed'({2'b00, x_init, {FB{1'b0}}});
         acc_b_ff <= signed'({2'b00, x_init, {FB{1'b0}}});
      end else if (ctl.step) begin
         acc_a_ff <= ctl.step_up ? acc_a_ff - slope_a : acc_a_ff + slope_a;
         acc_b_ff <= ctl.step_up ? acc_b_ff - slope_b : acc_b_ff + slope_b;
      end
      row1_ff  <= row;
      last1_ff <= ctl.last;
      row_ff   <= row1_ff;
      last_ff  <= last1_ff;
      start_ff <= rnd_a[CB-1:0];
      len_ff   <= len_in;
   end

   assign strobe      = strobe_ff;
   assign span_row    = row_ff;
   assign span_start  = start_ff;
   assign span_length = signed'(len_ff);
   assign last_span   = last_ff;

endmodule

### rtl/scanline_triangle_span_generator.sv
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+----------------------------
// request   | req_vertex_*, req_fill_color            | start high while busy low
// response  | rsp_span_*, rsp_last_span               | rsp_strobe high, one cycle
//
// setup is sort, product, five divisions on one shared divider, and load.
// then one span per cycle, a load state between halves, a drain state before busy drops.
// a triangle with all rows equal gives no spans and ends after setup.
// reset is synchronous and clears the sequencer and all strobes.
// the receiver cannot stall; spans leave as they are made.
`include "scanline_triangle_span_generator_defines.svh"
module scanline_triangle_span_generator import stsg_pkg::*; #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [COORD_BITS-1:0]       req_vertex_a_x,
   input  logic [COORD_BITS-1:0]       req_vertex_a_y,
   input  logic [COORD_BITS-1:0]       req_vertex_b_x,
   input  logic [COORD_BITS-1:0]       req_vertex_b_y,
   input  logic [COORD_BITS-1:0]       req_vertex_c_x,
   input  logic [COORD_BITS-1:0]       req_vertex_c_y,
   input  logic [COLOR_BITS-1:0]       req_fill_color,
   output logic                        rsp_strobe,
   output logic [COORD_BITS-1:0]       rsp_span_row,
   output logic [COORD_BITS-1:0]       rsp_span_start,
   output logic signed [COORD_BITS:0]  rsp_span_length,
   output logic [COLOR_BITS-1:0]       rsp_span_color,
   output logic                        rsp_last_span
);

   localparam int CB = COORD_BITS;
   localparam int FB = FRAC_BITS;
   localparam int AW = CB + FB + 2;
   localparam int NW = CB + FB;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic [CB-1:0] vx_ff [3];
   logic [CB-1:0] vy_ff [3];
   logic [CB-1:0] sx_ff [3];
   logic [CB-1:0] sy_ff [3];
   logic [CB-1:0] tx [3];
   logic [CB-1:0] ty [3];
   logic [COLOR_BITS-1:0] color_ff;

   logic signed [CB:0]      dyy, dxx;
   logic signed [2*CB+1:0]  prod_full;
   logic signed [2*CB:0]    prod_ff, prod_neg;
   logic [2*CB-1:0]         pmag;

   logic signed [CB:0] dx_s, dx_neg;
   logic [CB-1:0]      dy_u;
   logic [NW-1:0]      div_num;
   logic [CB-1:0]      div_den;
   logic               div_neg;
   logic               div_done, div_rem_nz;
   logic [NW-1:0]      div_quot;

   logic [AW-1:0]      qext, slope_val;
   logic [CB+1:0]      qs, qs_f, midx_w;

   logic signed [AW-1:0] slope_ta_ff, slope_tb_ff, slope_ba_ff, slope_bb_ff;
   logic [CB-1:0]        mid_x_ff, mid_y_ff, row_ff;
   logic                 top_any, bot_any;

   span_ctl_type  ctl;
   logic [CB-1:0] x_init;
   logic          span_strobe, span_last;

   function automatic logic after(input logic [CB-1:0] ax, input logic [CB-1:0] ay,
                                  input logic [CB-1:0] bx, input logic [CB-1:0] by);
      return (ay > by) || (ay == by && ax > bx);
   endfunction

   // three compare-swaps: sort by y then x
   always_comb begin
      logic [CB-1:0] hx, hy;
      hx = '0;
      hy = '0;
      for (int i = 0; i < 3; i++) begin
         tx[i] = vx_ff[i];
         ty[i] = vy_ff[i];
      end
      if (after(tx[0], ty[0], tx[1], ty[1])) begin
         hx = tx[0]; hy = ty[0];
         tx[0] = tx[1]; ty[0] = ty[1];
         tx[1] = hx; ty[1] = hy;
      end
      if (after(tx[0], ty[0], tx[2], ty[2])) begin
         hx = tx[0]; hy = ty[0];
         tx[0] = tx[2]; ty[0] = ty[2];
         tx[2] = hx; ty[2] = hy;
      end
      if (after(tx[1], ty[1], tx[2], ty[2])) begin
         hx = tx[1]; hy = ty[1];
         tx[1] = tx[2]; ty[1] = ty[2];
         tx[2] = hx; ty[2] = hy;
      end
   end

   // long edge product for the split point
   assign dyy       = signed'({1'b0, sy_ff[1]}) - signed'({1'b0, sy_ff[0]});
   assign dxx       = signed'({1'b0, sx_ff[2]}) - signed'({1'b0, sx_ff[0]});
   assign prod_full = dyy * dxx;
   assign prod_neg  = -prod_ff;
   assign pmag      = prod_ff[2*CB] ? prod_neg[2*CB-1:0] : prod_ff[2*CB-1:0];

   // divider operands per job
   always_comb begin
      dx_s = '0;
      dy_u = '0;
      unique case (job_ff)
         JOB_TOP_A: begin
            dx_s = signed'({1'b0, sx_ff[1]}) - signed'({1'b0, sx_ff[0]});
            dy_u = sy_ff[1] - sy_ff[0];
         end
         JOB_TOP_B: begin
            dx_s = signed'({1'b0, mid_x_ff}) - signed'({1'b0, sx_ff[0]});
            dy_u = mid_y_ff - sy_ff[0];
         end
         JOB_BOT_A: begin
            dx_s = signed'({1'b0, sx_ff[2]}) - signed'({1'b0, sx_ff[1]});
            dy_u = sy_ff[2] - sy_ff[1];
         end
         JOB_BOT_B: begin
            dx_s = signed'({1'b0, sx_ff[2]}) - signed'({1'b0, mid_x_ff});
            dy_u = sy_ff[2] - mid_y_ff;
         end
         default: begin
            dx_s = '0;
            dy_u = '0;
         end
      endcase
   end

   assign dx_neg = -dx_s;

   always_comb begin
      if (job_ff == JOB_SPLIT) begin
         div_num = NW'(pmag);
         div_den = sy_ff[2] - sy_ff[0];
         div_neg = prod_ff[2*CB];
      end else begin
         div_num = {(dx_s[CB] ? dx_neg[CB-1:0] : dx_s[CB-1:0]), {FB{1'b0}}};
         div_den = dy_u;
         div_neg = dx_s[CB];
      end
   end

   stsg_div #(.NW(NW), .DW(CB)) u_div (
      .clock  (clock),
      .reset  (reset),
      .go     (state_ff == ST_DIV_GO),
      .num    (div_num),
      .den    (div_den),
      .done   (div_done),
      .quot   (div_quot),
      .rem_nz (div_rem_nz)
   );

   // signed slope, zero for an empty edge
   assign qext      = {2'b00, div_quot};
   assign slope_val = (dy_u == '0) ? '0 : (div_neg ? (~qext + AW'(1)) : qext);

   // floored split x
   assign qs     = {2'b00, div_quot[CB-1:0]};
   assign qs_f   = div_neg ? (~qs + (CB+2)'(1) - (CB+2)'(div_rem_nz)) : qs;
   assign midx_w = qs_f + {2'b00, sx_ff[0]};

   assign top_any = (sy_ff[1] != sy_ff[0]);
   assign bot_any = (sy_ff[2] != mid_y_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      ctl      = '0;
      x_init   = sx_ff[0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SORT;
         end
         ST_SORT: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            job_in   = JOB_SPLIT;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               unique case (job_ff)
                  JOB_SPLIT: begin
                     job_in = JOB_TOP_A;
                     state_in = ST_DIV_GO;
                  end
                  JOB_TOP_A: begin
                     job_in = JOB_TOP_B;
                     state_in = ST_DIV_GO;
                  end
                  JOB_TOP_B: begin
                     job_in = JOB_BOT_A;
                     state_in = ST_DIV_GO;
                  end
                  JOB_BOT_A: begin
                     job_in = JOB_BOT_B;
                     state_in = ST_DIV_GO;
                  end
                  default: state_in = ST_LOAD_TOP;
               endcase
            end
         end
         ST_LOAD_TOP: begin
            ctl.load = top_any;
            state_in = top_any ? ST_EMIT_TOP : ST_LOAD_BOT;
         end
         ST_EMIT_TOP: begin
            ctl.step = 1'b1;
            ctl.last = (row_ff == sy_ff[1]) && !bot_any;
            if (row_ff == sy_ff[1]) state_in = ST_LOAD_BOT;
         end
         ST_LOAD_BOT: begin
            x_init   = sx_ff[2];
            ctl.load = bot_any;
            if (bot_any) state_in = ST_EMIT_BOT;
            else if (top_any) state_in = ST_DRAIN;
            else state_in = ST_IDLE;
         end
         ST_EMIT_BOT: begin
            x_init      = sx_ff[2];
            ctl.step    = 1'b1;
            ctl.step_up = 1'b1;
            ctl.last    = (row_ff == mid_y_ff + CB'(1));
            if (ctl.last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (span_strobe && span_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_SPLIT;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   // triangle registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         vx_ff[0] <= req_vertex_a_x;
         vy_ff[0] <= req_vertex_a_y;
         vx_ff[1] <= req_vertex_b_x;
         vy_ff[1] <= req_vertex_b_y;
         vx_ff[2] <= req_vertex_c_x;
         vy_ff[2] <= req_vertex_c_y;
         color_ff <= req_fill_color;
      end
      if (state_ff == ST_SORT) begin
         for (int i = 0; i < 3; i++) begin
            sx_ff[i] <= tx[i];
            sy_ff[i] <= ty[i];
         end
      end
      if (state_ff == ST_MUL) prod_ff <= prod_full[2*CB:0];
      if (state_ff == ST_DIV_WAIT && div_done) begin
         case (job_ff)
            JOB_SPLIT: begin
               if (sy_ff[1] == sy_ff[2]) begin
                  mid_x_ff <= sx_ff[2];
                  mid_y_ff <= sy_ff[2];
               end else if (sy_ff[0] == sy_ff[1]) begin
                  mid_x_ff <= sx_ff[0];
                  mid_y_ff <= sy_ff[0];
               end else begin
                  mid_x_ff <= midx_w[CB-1:0];
                  mid_y_ff <= sy_ff[1];
               end
            end
            JOB_TOP_A: slope_ta_ff <= signed'(slope_val);
            JOB_TOP_B: slope_tb_ff <= signed'(slope_val);
            JOB_BOT_A: slope_ba_ff <= signed'(slope_val);
            default:   slope_bb_ff <= signed'(slope_val);
         endcase
      end
      // row walk
      if (state_ff == ST_LOAD_TOP) row_ff <= sy_ff[0] + CB'(1);
      else if (state_ff == ST_EMIT_TOP) row_ff <= row_ff + CB'(1);
      else if (state_ff == ST_LOAD_BOT) row_ff <= sy_ff[2];
      else if (state_ff == ST_EMIT_BOT) row_ff <= row_ff - CB'(1);
   end

   stsg_span #(.CB(CB), .FB(FB)) u_span (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .x_init      (x_init),
      .row         (row_ff),
      .slope_a     (state_ff == ST_EMIT_BOT ? slope_ba_ff : slope_ta_ff),
      .slope_b     (state_ff == ST_EMIT_BOT ? slope_bb_ff : slope_tb_ff),
      .strobe      (span_strobe),
      .span_row    (rsp_span_row),
      .span_start  (rsp_span_start),
      .span_length (rsp_span_length),
      .last_span   (span_last)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = span_strobe;
   assign rsp_last_span  = span_last;
   assign rsp_span_color = color_ff;

   `STSG_ASSERT(a_idle_quiet, clock, reset, !busy |-> !rsp_strobe, "span while idle")
   `STSG_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "transfer not followed by busy")
   `STSG_ASSERT_NORST(a_last_alone, clock, (!reset && rsp_strobe && rsp_last_span) |=> !rsp_strobe, "span after last span")

endmodule
